// File: design/free_list_heap_allocator_top_defines.svh
// assertion macros for the free list heap allocator
`ifndef FREE_LIST_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FREE_LIST_HEAP_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FLA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FLA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define FLA_ASSERT(lbl, clk, rstn, prop, msg)
`define FLA_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// File: design/fla_pkg.sv
// shared types and constants of the free list heap allocator
package fla_pkg;

    localparam int ARENA_BYTES_DEF    = 32768;
    localparam int TOP_HDR_BYTES_DEF  = 8;
    localparam int FREE_HDR_BYTES_DEF = 6;
    localparam int BUSY_HDR_BYTES_DEF = 4;

    // byte address width, wide enough for any link plus any size
    localparam int ADDR_W = 18;

    localparam logic [1:0] FN_ALLOC = 2'd0;
    localparam logic [1:0] FN_FREE  = 2'd1;
    localparam logic [1:0] FN_QUERY = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [14:0] req_size;
        logic [14:0] user_addr;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [14:0] granted_addr;
        logic [14:0] usable_size;
    } t_rsp;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
    } t_mem_req;

endpackage

// File: design/fla_mem.sv
// arena: two byte banks, one 16-bit access per cycle at any byte address once cleared
module fla_mem import fla_pkg::*; #(
    parameter int ARENA_BYTES   = ARENA_BYTES_DEF,
    parameter int TOP_HDR_BYTES = TOP_HDR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mem_req    i_req,
    input  logic [15:0] i_wdata,
    output logic [15:0] o_rdata,
    output logic        o_ready
);

    localparam int WORDS = (ARENA_BYTES + 1) / 2;
    localparam int IDX_W = $clog2(WORDS);
    localparam logic [15:0]       HDR_SIZE = 16'(ARENA_BYTES - TOP_HDR_BYTES);
    localparam logic [ADDR_W-1:0] A_ARENA  = ADDR_W'(ARENA_BYTES);
    localparam logic [ADDR_W-1:0] A_TOP    = ADDR_W'(TOP_HDR_BYTES);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WORDS - 1);

    logic [7:0] r_bank_ev [WORDS];
    logic [7:0] r_bank_od [WORDS];

    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_idx;

    logic              odd;
    logic [ADDR_W-1:0] a_hi;
    logic              lo_ok, hi_ok, ev_ok, od_ok;
    logic [IDX_W-1:0]  idx_ev, idx_od;
    logic [7:0]        wr_ev, wr_od;
    logic [ADDR_W-1:0] clr_ev_addr, clr_od_addr;
    logic [7:0]        clr_ev, clr_od;

    logic       r_odd, r_ev_ok, r_od_ok;
    logic [7:0] r_rd_ev, r_rd_od;

    always_comb begin
        odd    = i_req.addr[0];
        a_hi   = i_req.addr + ADDR_W'(1);
        lo_ok  = i_req.addr < A_ARENA;
        hi_ok  = a_hi < A_ARENA;
        idx_od = i_req.addr[IDX_W:1];
        idx_ev = odd ? idx_od + IDX_W'(1) : idx_od;
        ev_ok  = odd ? hi_ok : lo_ok;
        od_ok  = odd ? lo_ok : hi_ok;
        wr_ev  = odd ? i_wdata[15:8] : i_wdata[7:0];
        wr_od  = odd ? i_wdata[7:0]  : i_wdata[15:8];

        // reset image: only the first header's size is nonzero
        clr_ev_addr = {{(ADDR_W-IDX_W-1){1'b0}}, r_clr_idx, 1'b0};
        clr_od_addr = {{(ADDR_W-IDX_W-1){1'b0}}, r_clr_idx, 1'b1};
        clr_ev = (clr_ev_addr == A_TOP) ? HDR_SIZE[7:0] :
                 (clr_ev_addr == A_TOP + ADDR_W'(1)) ? HDR_SIZE[15:8] : 8'h00;
        clr_od = (clr_od_addr == A_TOP) ? HDR_SIZE[7:0] :
                 (clr_od_addr == A_TOP + ADDR_W'(1)) ? HDR_SIZE[15:8] : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + IDX_W'(1);
            if (r_clr_idx == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_bank_ev[r_clr_idx] <= clr_ev;
            r_bank_od[r_clr_idx] <= clr_od;
        end else if (i_req.en && i_req.we) begin
            if (ev_ok) begin
                r_bank_ev[idx_ev] <= wr_ev;
            end
            if (od_ok) begin
                r_bank_od[idx_od] <= wr_od;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && !i_req.we) begin
            r_rd_ev <= r_bank_ev[idx_ev];
            r_rd_od <= r_bank_od[idx_od];
            r_odd   <= odd;
            r_ev_ok <= ev_ok;
            r_od_ok <= od_ok;
        end
    end

    always_comb begin
        o_rdata[7:0]  = r_odd ? (r_od_ok ? r_rd_od : 8'h00) : (r_ev_ok ? r_rd_ev : 8'h00);
        o_rdata[15:8] = r_odd ? (r_ev_ok ? r_rd_ev : 8'h00) : (r_od_ok ? r_rd_od : 8'h00);
    end

    assign o_ready = !r_clr_busy;

endmodule

// File: design/free_list_heap_allocator_top.sv
// free list heap allocator: top level with the request sequencer
// allocate walks the free list block by block, then splits the picked block or unlinks it;
// an unlink and every free relink each busy block that follows, up to the next free block
// requests: one at a time, the next accepted once the response is loaded into the output register
// reset: synchronous active low; afterwards a clearing pass over all (ARENA_BYTES+1)/2 arena words
//   writes the initial arena image, and no request is accepted until it ends
`include "free_list_heap_allocator_top_defines.svh"

module free_list_heap_allocator_top import fla_pkg::*; #(
    parameter int ARENA_BYTES    = ARENA_BYTES_DEF,
    parameter int TOP_HDR_BYTES  = TOP_HDR_BYTES_DEF,
    parameter int FREE_HDR_BYTES = FREE_HDR_BYTES_DEF,
    parameter int BUSY_HDR_BYTES = BUSY_HDR_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_req       i_in_req,
    // response channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_rsp       o_out_rsp,
    // fit policy register
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);

    localparam int CNT_W = $clog2(ARENA_BYTES + 1);
    localparam logic [CNT_W-1:0]  C_LIMIT = CNT_W'(ARENA_BYTES);
    localparam logic [ADDR_W-1:0] A_ARENA = ADDR_W'(ARENA_BYTES);
    localparam logic [ADDR_W-1:0] A_TOP   = ADDR_W'(TOP_HDR_BYTES);
    localparam logic [ADDR_W-1:0] A_FREE  = ADDR_W'(FREE_HDR_BYTES);
    localparam logic [ADDR_W-1:0] A_BUSY  = ADDR_W'(BUSY_HDR_BYTES);
    localparam logic [ADDR_W-1:0] A_TWO   = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] A_FOUR  = ADDR_W'(4);

    typedef enum logic [5:0] {
        S_IDLE,
        // free list walk for allocate
        S_CH_CHK, S_CH_SZ, S_CH_NX, S_CH_END,
        // allocate: split or unlink
        S_AL_SZ, S_AL_W2, S_AL_W3, S_AL_NX, S_AL_PV, S_AL_L2, S_AL_L3, S_AL_DONE,
        // free with coalescing
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8, S_F9,
        S_F10, S_F11, S_F12, S_F13, S_FE1, S_FE2, S_FRL, S_FRL2,
        // back-link relink walk shared by allocate and free
        S_RL_CHK, S_RL_SZ,
        // size query
        S_Q0, S_Q1,
        S_FIN
    } t_state;

    t_state r_state;

    logic [1:0]        r_policy;
    logic [14:0]       r_first_free;
    logic              r_out_valid;
    t_rsp              r_out_rsp;
    t_rsp              r_res;
    logic [1:0]        r_func;

    logic [ADDR_W-1:0] r_want, r_cur, r_pick, r_busy, r_b, r_nb, r_m;
    logic [15:0]       r_pick_sz, r_sz, r_nx, r_pv, r_pf, r_nf, r_nxt;
    logic [16:0]       r_size;
    logic [CNT_W-1:0]  r_cnt;
    // relink walk: current block, stop address, back-link target
    logic [ADDR_W-1:0] r_ra;
    logic [15:0]       r_stop, r_tgt;

    t_mem_req          m_req;
    logic [15:0]       m_wdata, m_rdata;
    logic              m_ready;

    logic              in_acc;
    logic              out_free;
    logic [ADDR_W-1:0] rd_a;
    logic [ADDR_W-1:0] want_in;
    logic [ADDR_W-1:0] ua_in;
    logic              ua_ok;
    logic              ch_fit, ch_stop;
    logic              al_split;
    logic              f_merge;
    logic              f_adj;
    logic              rl_go;

    fla_mem #(
        .ARENA_BYTES  (ARENA_BYTES),
        .TOP_HDR_BYTES(TOP_HDR_BYTES)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (m_req),
        .i_wdata(m_wdata),
        .o_rdata(m_rdata),
        .o_ready(m_ready)
    );

    assign o_in_stall  = !(r_state == S_IDLE && m_ready);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        rd_a    = ADDR_W'(m_rdata);
        // total block size: header added, raised to the free header size
        want_in = ADDR_W'(i_in_req.req_size) + A_BUSY;
        if (want_in < A_FREE) begin
            want_in = A_FREE;
        end
        ua_in   = ADDR_W'(i_in_req.user_addr);
        ua_ok   = ua_in >= A_TOP + A_BUSY;
        ch_fit  = rd_a >= r_want;
        // first fit stops at the first fit, best fit at an exact fit
        ch_stop = ch_fit && ((r_policy == POL_BEST) ? (rd_a == r_want)
                                                    : (r_policy != POL_WORST));
        al_split = rd_a >= r_want + A_FREE + ADDR_W'(1);
        f_merge  = (r_nf != 16'd0) && (r_nb == ADDR_W'(r_nf));
        // previous free block ends right where this one starts
        f_adj    = (ADDR_W'(r_pf) + rd_a) == r_b;
        rl_go    = (r_ra < A_ARENA) && (r_ra != ADDR_W'(r_stop)) && (r_cnt < C_LIMIT);
    end

    // at most one arena access per state
    always_comb begin
        m_req   = '0;
        m_wdata = '0;
        unique case (r_state)
            S_CH_CHK: begin
                if (r_cur != '0 && r_cnt < C_LIMIT) begin
                    m_req = '{en: 1'b1, we: 1'b0, addr: r_cur};
                end
            end
            S_CH_SZ: begin
                if (!ch_stop) begin
                    m_req = '{en: 1'b1, we: 1'b0, addr: r_cur + A_TWO};
                end
            end
            S_CH_END: begin
                if (r_pick != '0) begin
                    m_req = '{en: 1'b1, we: 1'b0, addr: r_pick};
                end
            end
            S_AL_SZ: begin
                if (al_split) begin
                    m_req   = '{en: 1'b1, we: 1'b1, addr: r_pick};
                    m_wdata = 16'(rd_a - r_want);
                end else begin
                    m_req = '{en: 1'b1, we: 1'b0, addr: r_pick + A_TWO};
                end
            end
            S_AL_W2: begin
                m_req   = '{en: 1'b1, we: 1'b1, addr: r_busy};
                m_wdata = 16'(r_want);
            end
            S_AL_W3: begin
                m_req   = '{en: 1'b1, we: 1'b1, addr: r_busy + A_TWO};
                m_wdata = 16'(r_pick);
            end
            S_AL_NX: begin
                m_req = '{en: 1'b1, we: 1'b0, addr: r_pick + A_FOUR};
            end
            S_AL_PV: begin
                if (m_rdata != 16'd0) begin
                    m_req   = '{en: 1'b1, we: 1'b1, addr: rd_a + A_TWO};
                    m_wdata = r_nx;
                end
            end
            S_AL_L2: begin
                if (r_nx != 16'd0) begin
                    m_req   = '{en: 1'b1, we: 1'b1, addr: ADDR_W'(r_nx) + A_FOUR};
                    m_wdata = r_pv;
                end
            end
            S_AL_L3: begin
                m_req   = '{en: 1'b1, we: 1'b1, addr: r_pick + A_TWO};
                m_wdata = r_pv;
            end
            S_RL_CHK: begin
                if (rl_go) begin
                    m_req = '{en: 1'b1, we: 1'b0, addr: r_ra};
                end
            end
            S_RL_SZ: begin
                if (m_rdata != 16'd0) begin
                    m_req   = '{en: 1'b1, we: 1'b1, addr: r_ra + A_TWO};
                    m_wdata = r_tgt;
                end
            end
            S_F0, S_Q0: begin
                m_req = '{en: 1'b1, we: 1'b0, addr: r_b};
            end
            S_F1: begin
                m_req = '{en: 1'b1, we: 1'b0, addr: r_b + A_TWO};
            end
            S_F2: begin
                if (m_rdata != 16'd0) begin
                    m_req = '{en: 1'b1, we: 1'b0, addr: rd_a + A_TWO};
                end
            end
            S_F4: begin
                if (f_merge) begin
                    m_req = '{en: 1'b1, we: 1'b0, addr: ADDR_W'(r_nf)};
                end else if (r_nf != 16'd0) begin
                    m_req   = '{en: 1'b1, we: 1'b1, addr: ADDR_W'(r_nf) + A_FOUR};
                    m_wdata = 16'(r_b);
                end
            end
            S_F5: begin
                m_req = '{en: 1'b1, we: 1'b0, addr: ADDR_W'(r_nf) + A_TWO};
            end
            S_F6: begin
                if (m_rdata != 16'd0) begin
                    m_req   = '{en: 1'b1, we: 1'b1, addr: rd_a + A_FOUR};
                    m_wdata = 16'(r_b);
                end
            end
            S_F7: begin
                m_req   = '{en: 1'b1, we: 1'b1, addr: r_b};
                m_wdata = r_size[15:0];
            end
            S_F8: begin
                m_req   = '{en: 1'b1, we: 1'b1, addr: r_b + A_TWO};
                m_wdata = r_nxt;
            end
            S_F9: begin
                if (r_pf != 16'd0) begin
                    m_req = '{en: 1'b1, we: 1'b0, addr: ADDR_W'(r_pf)};
                end
            end
            S_F10: begin
                if (f_adj) begin
                    m_req   = '{en: 1'b1, we: 1'b1, addr: ADDR_W'(r_pf) + A_TWO};
                    m_wdata = r_nxt;
                end
            end
            S_F11: begin
                m_req = '{en: 1'b1, we: 1'b0, addr: ADDR_W'(r_pf)};
            end
            S_F12: begin
                m_req   = '{en: 1'b1, we: 1'b1, addr: ADDR_W'(r_pf)};
                m_wdata = 16'(17'(m_rdata) + r_size);
            end
            S_F13: begin
                if (r_nxt != 16'd0) begin
                    m_req   = '{en: 1'b1, we: 1'b1, addr: ADDR_W'(r_nxt) + A_FOUR};
                    m_wdata = r_pf;
                end
            end
            S_FE1: begin
                m_req   = '{en: 1'b1, we: 1'b1, addr: r_b + A_FOUR};
                m_wdata = r_pf;
            end
            S_FE2: begin
                if (r_pf != 16'd0) begin
                    m_req   = '{en: 1'b1, we: 1'b1, addr: ADDR_W'(r_pf) + A_TWO};
                    m_wdata = 16'(r_b);
                end
            end
            S_FRL: begin
                m_req = '{en: 1'b1, we: 1'b0, addr: r_m};
            end
            default: begin
                m_req   = '0;
                m_wdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_policy     <= POL_FIRST;
            r_first_free <= 15'(TOP_HDR_BYTES);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            // the final state reloads the output register itself
            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func    <= i_in_req.func;
                        r_res     <= '0;
                        r_want    <= want_in;
                        r_cur     <= ADDR_W'(r_first_free);
                        r_pick    <= '0;
                        r_pick_sz <= '0;
                        r_cnt     <= '0;
                        r_b       <= ua_in - A_BUSY;
                        priority if (i_in_req.func == FN_ALLOC) begin
                            r_state <= S_CH_CHK;
                        end else if (i_in_req.func == FN_FREE && ua_ok) begin
                            r_state <= S_F0;
                        end else if (i_in_req.func == FN_QUERY && ua_ok) begin
                            r_state <= S_Q0;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end

                // walk the free list, bounded by the arena size in steps
                S_CH_CHK: begin
                    r_state <= (r_cur != '0 && r_cnt < C_LIMIT) ? S_CH_SZ : S_CH_END;
                end
                S_CH_SZ: begin
                    if (ch_fit) begin
                        priority if (r_policy == POL_BEST) begin
                            if (r_pick == '0 || m_rdata < r_pick_sz) begin
                                r_pick    <= r_cur;
                                r_pick_sz <= m_rdata;
                            end
                        end else if (r_policy == POL_WORST) begin
                            // ties go to the higher address
                            if (r_pick == '0 || m_rdata >= r_pick_sz) begin
                                r_pick    <= r_cur;
                                r_pick_sz <= m_rdata;
                            end
                        end else begin
                            r_pick <= r_cur;
                        end
                    end
                    r_state <= ch_stop ? S_CH_END : S_CH_NX;
                end
                S_CH_NX: begin
                    r_cur   <= rd_a;
                    r_cnt   <= r_cnt + CNT_W'(1);
                    r_state <= S_CH_CHK;
                end
                S_CH_END: begin
                    if (r_pick == '0) begin
                        r_res   <= '{status: 1'b1, granted_addr: '0, usable_size: '0};
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_AL_SZ;
                    end
                end

                // split from the high end, or take the whole block off the list
                S_AL_SZ: begin
                    r_sz <= m_rdata;
                    if (al_split) begin
                        r_busy  <= r_pick + rd_a - r_want;
                        r_state <= S_AL_W2;
                    end else begin
                        r_state <= S_AL_NX;
                    end
                end
                S_AL_W2: r_state <= S_AL_W3;
                S_AL_W3: r_state <= S_AL_DONE;
                S_AL_NX: begin
                    r_nx    <= m_rdata;
                    r_state <= S_AL_PV;
                end
                S_AL_PV: begin
                    r_pv <= m_rdata;
                    if (m_rdata == 16'd0) begin
                        r_first_free <= r_nx[14:0];
                    end
                    r_state <= S_AL_L2;
                end
                S_AL_L2: r_state <= S_AL_L3;
                S_AL_L3: begin
                    r_busy  <= r_pick;
                    r_want  <= ADDR_W'(r_sz);
                    r_ra    <= r_pick + ADDR_W'(r_sz);
                    r_stop  <= r_nx;
                    r_tgt   <= r_pv;
                    r_cnt   <= '0;
                    r_state <= S_RL_CHK;
                end
                S_AL_DONE: begin
                    r_res.status       <= 1'b0;
                    r_res.granted_addr <= 15'(r_busy + A_BUSY);
                    r_res.usable_size  <= (r_want >= A_BUSY) ? 15'(r_want - A_BUSY) : 15'd0;
                    r_state            <= S_FIN;
                end

                // point each busy block up to the stop address at the target
                S_RL_CHK: begin
                    if (rl_go) begin
                        r_state <= S_RL_SZ;
                    end else begin
                        r_state <= (r_func == FN_ALLOC) ? S_AL_DONE : S_FIN;
                    end
                end
                S_RL_SZ: begin
                    if (m_rdata != 16'd0) begin
                        r_ra    <= r_ra + rd_a;
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= S_RL_CHK;
                    end else begin
                        r_state <= (r_func == FN_ALLOC) ? S_AL_DONE : S_FIN;
                    end
                end

                // free: find neighbors through the back-link
                S_F0: r_state <= S_F1;
                S_F1: begin
                    r_size  <= 17'(m_rdata);
                    r_nb    <= r_b + rd_a;
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_pf <= m_rdata;
                    if (m_rdata != 16'd0) begin
                        r_state <= S_F3;
                    end else begin
                        r_nf    <= 16'(r_first_free);
                        r_state <= S_F4;
                    end
                end
                S_F3: begin
                    r_nf    <= m_rdata;
                    r_state <= S_F4;
                end
                S_F4: begin
                    if (f_merge) begin
                        r_state <= S_F5;
                    end else begin
                        r_nxt   <= r_nf;
                        r_state <= S_F7;
                    end
                end
                S_F5: begin
                    r_size  <= r_size + 17'(m_rdata);
                    r_state <= S_F6;
                end
                S_F6: begin
                    r_nxt   <= m_rdata;
                    r_state <= S_F7;
                end
                S_F7: r_state <= S_F8;
                S_F8: r_state <= S_F9;
                S_F9: r_state <= (r_pf != 16'd0) ? S_F10 : S_FE1;
                S_F10: r_state <= f_adj ? S_F11 : S_FE1;
                S_F11: r_state <= S_F12;
                S_F12: r_state <= S_F13;
                S_F13: begin
                    r_m     <= ADDR_W'(r_pf);
                    r_state <= S_FRL;
                end
                S_FE1: r_state <= S_FE2;
                S_FE2: begin
                    if (r_pf == 16'd0) begin
                        r_first_free <= r_b[14:0];
                    end
                    r_m     <= r_b;
                    r_state <= S_FRL;
                end
                S_FRL: r_state <= S_FRL2;
                S_FRL2: begin
                    r_ra    <= r_m + rd_a;
                    r_stop  <= r_nxt;
                    r_tgt   <= 16'(r_m);
                    r_cnt   <= '0;
                    r_state <= S_RL_CHK;
                end

                S_Q0: r_state <= S_Q1;
                S_Q1: begin
                    r_res.usable_size <= (rd_a >= A_BUSY) ? 15'(rd_a - A_BUSY) : 15'd0;
                    r_state           <= S_FIN;
                end

                // hand the response to the output register once it has room
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_rsp   <= r_res;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    `FLA_ASSERT_NEVER(a_no_access_in_clear, i_clk, i_rst_n, !m_ready && m_req.en, "arena access during clearing pass")
    `FLA_ASSERT(a_fail_zero, i_clk, i_rst_n, r_out_valid && r_out_rsp.status |-> r_out_rsp.granted_addr == '0 && r_out_rsp.usable_size == '0, "failed allocation carries nonzero fields")
    `FLA_ASSERT(a_walk_bound, i_clk, i_rst_n, r_state != S_IDLE |-> r_cnt <= C_LIMIT, "walk counter past limit")
    `FLA_ASSERT(a_leave_idle, i_clk, i_rst_n, in_acc |=> r_state != S_IDLE, "accepted request not started")

endmodule

// File: sim/free_list_heap_allocator_top_tb.sv
// self-checking testbench of the free list heap allocator top level
`timescale 1ns / 100ps

module free_list_heap_allocator_top_tb;
    import fla_pkg::*;

    localparam int ARENA      = ARENA_BYTES_DEF;
    localparam int TOP_HDR    = TOP_HDR_BYTES_DEF;
    localparam int FREE_HDR   = FREE_HDR_BYTES_DEF;
    localparam int BUSY_HDR   = BUSY_HDR_BYTES_DEF;
    localparam int HEAP_WORDS = (ARENA + 1) / 2;
    localparam int WALK_MAX   = ARENA;
    localparam logic [1:0] FN_NOP = 2'd3;   // unused operation code
    localparam logic [1:0] POL_SPARE = 2'd3; // unused policy, behaves as first fit
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 256;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_req in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_rsp out_rsp;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_wdata = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    free_list_heap_allocator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------
    // arena model: byte-addressed view of a 16-bit word store
    // ---------------------------------------------------------------
    bit [15:0]   heap_mem [HEAP_WORDS];
    int unsigned head_free;
    bit [1:0]    fit_mode;

    function automatic int unsigned peek8(int unsigned a);
        if (a >= ARENA) return 0;
        return (heap_mem[a >> 1] >> ((a & 1) * 8)) & 8'hff;
    endfunction

    function automatic void poke8(int unsigned a, int unsigned v);
        if (a >= ARENA) return;
        if (a & 1) heap_mem[a >> 1][15:8] = v[7:0];
        else heap_mem[a >> 1][7:0] = v[7:0];
    endfunction

    function automatic int unsigned peek16(int unsigned a);
        return peek8(a) | (peek8(a + 1) << 8);
    endfunction

    function automatic void poke16(int unsigned a, int unsigned v);
        poke8(a, v);
        poke8(a + 1, v >> 8);
    endfunction

    function automatic void heap_reset();
        foreach (heap_mem[i]) heap_mem[i] = '0;
        fit_mode  = POL_FIRST;
        head_free = TOP_HDR;
        poke16(TOP_HDR, ARENA - TOP_HDR);
    endfunction

    // point every busy block from addr up to stop back at target
    function automatic void retarget_busy(int unsigned addr, int unsigned stop,
                                          int unsigned target);
        int unsigned n = 0;
        int unsigned sz;
        while (addr < ARENA && addr != stop && n < WALK_MAX) begin
            sz = peek16(addr);
            if (sz == 0) break;
            poke16(addr + 2, target);
            addr += sz;
            n++;
        end
    endfunction

    function automatic int unsigned pick_block(int unsigned want);
        int unsigned cur = head_free;
        int unsigned pick = 0, pick_sz = 0, n = 0, sz;
        while (cur != 0 && n < WALK_MAX) begin
            sz = peek16(cur);
            if (sz >= want) begin
                if (fit_mode == POL_BEST) begin
                    if (pick == 0 || sz < pick_sz) begin
                        pick = cur;
                        pick_sz = sz;
                    end
                    if (sz == want) break;
                end else if (fit_mode == POL_WORST) begin
                    if (pick == 0 || sz >= pick_sz) begin
                        pick = cur;
                        pick_sz = sz;
                    end
                end else begin
                    return cur;
                end
            end
            cur = peek16(cur + 2);
            n++;
        end
        return pick;
    endfunction

    function automatic bit grant_block(int unsigned req, output int unsigned addr,
                                       output int unsigned usable);
        int unsigned want = req + BUSY_HDR;
        int unsigned blk, sz, busy, nx, pv;
        addr = 0;
        usable = 0;
        if (want < FREE_HDR) want = FREE_HDR;
        blk = pick_block(want);
        if (blk == 0) return 1'b0;
        sz = peek16(blk);
        if (sz >= want + FREE_HDR + 1) begin
            // split: busy part comes off the high end
            poke16(blk, sz - want);
            busy = blk + (sz - want);
            poke16(busy, want);
            poke16(busy + 2, blk);
        end else begin
            nx = peek16(blk + 2);
            pv = peek16(blk + 4);
            if (pv != 0) poke16(pv + 2, nx);
            else head_free = nx & 16'h7fff;
            if (nx != 0) poke16(nx + 4, pv);
            busy = blk;
            poke16(busy + 2, pv);
            retarget_busy(blk + sz, nx, pv);
            want = sz;
        end
        addr = (busy + BUSY_HDR) & 16'h7fff;
        usable = (want >= BUSY_HDR) ? ((want - BUSY_HDR) & 16'h7fff) : 0;
        return 1'b1;
    endfunction

    function automatic void release_block(int unsigned b);
        int unsigned size = peek16(b);
        int unsigned nb = b + size;
        int unsigned pf = peek16(b + 2);
        int unsigned nf, nxt, m;
        nf = (pf != 0) ? peek16(pf + 2) : head_free;
        if (nf != 0 && nb == nf) begin
            size += peek16(nf);
            nxt = peek16(nf + 2);
            if (nxt != 0) poke16(nxt + 4, b);
        end else begin
            nxt = nf;
            if (nf != 0) poke16(nf + 4, b);
        end
        poke16(b, size);
        poke16(b + 2, nxt);
        if (pf != 0 && pf + peek16(pf) == b) begin
            poke16(pf + 2, nxt);
            poke16(pf, peek16(pf) + size);
            if (nxt != 0) poke16(nxt + 4, pf);
            m = pf;
        end else begin
            poke16(b + 4, pf);
            if (pf != 0) poke16(pf + 2, b);
            else head_free = b & 16'h7fff;
            m = b;
        end
        retarget_busy(m + peek16(m), nxt, m);
    endfunction

    function automatic t_rsp heap_response(t_req r);
        t_rsp rsp = '0;
        int unsigned ua = r.user_addr;
        int unsigned addr, usable, sz;
        bit addr_ok = (ua >= TOP_HDR + BUSY_HDR);
        if (r.func == FN_ALLOC) begin
            if (grant_block(r.req_size, addr, usable)) begin
                rsp.granted_addr = addr[14:0];
                rsp.usable_size  = usable[14:0];
            end else begin
                rsp.status = 1'b1;
            end
        end else if (r.func == FN_FREE) begin
            if (addr_ok) release_block(ua - BUSY_HDR);
        end else if (r.func == FN_QUERY) begin
            if (addr_ok) begin
                sz = peek16(ua - BUSY_HDR);
                usable = (sz >= BUSY_HDR) ? ((sz - BUSY_HDR) & 16'h7fff) : 0;
                rsp.usable_size = usable[14:0];
            end
        end
        return rsp;
    endfunction

    // ---------------------------------------------------------------
    // request bookkeeping
    // ---------------------------------------------------------------
    t_req        pending_reqs[$];
    t_rsp        expected_rsps[$];
    int unsigned live_blocks[$];   // user addresses of blocks the model holds busy
    int n_granted, n_refused, n_frees, n_queries, n_other;
    int n_checked, n_errors;

    // predict the response, queue the request, and track live blocks
    task automatic issue(logic [1:0] fn, int unsigned req_sz, int unsigned ua,
                         output t_rsp rsp);
        t_req r;
        r.func = fn;
        r.req_size = req_sz[14:0];
        r.user_addr = ua[14:0];
        rsp = heap_response(r);
        pending_reqs.push_back(r);
        expected_rsps.push_back(rsp);
        case (fn)
            FN_ALLOC: begin
                if (rsp.status) n_refused++;
                else begin
                    n_granted++;
                    live_blocks.push_back(rsp.granted_addr);
                end
            end
            FN_FREE: n_frees++;
            FN_QUERY: n_queries++;
            default: n_other++;
        endcase
    endtask

    task automatic free_live(int idx);
        t_rsp rsp;
        int unsigned ua = live_blocks[idx];
        live_blocks.delete(idx);
        issue(FN_FREE, $urandom_range(0, 32767), ua, rsp);
    endtask

    task automatic drain_and_set_policy(logic [1:0] pol);
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);   // let the block settle before touching the register
        cfg_we    <= 1'b1;
        cfg_wdata <= pol;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        fit_mode = pol;
        @(negedge i_clk);
    endtask

    task automatic directed_items();
        t_rsp ra, rb, rc, rd;
        issue(FN_ALLOC, 0, 32767, ra);        // zero size raised to a free header
        issue(FN_ALLOC, 1, 0, ra);
        issue(FN_ALLOC, 2, 0, ra);
        issue(FN_ALLOC, 32767, 0, ra);        // larger than the arena: refused
        issue(FN_QUERY, 32767, 0, ra);        // address below the headers
        issue(FN_QUERY, 0, TOP_HDR + BUSY_HDR - 1, ra);
        issue(FN_FREE, 0, 0, ra);             // ignored frees
        issue(FN_FREE, 32767, TOP_HDR + BUSY_HDR - 1, ra);
        issue(FN_NOP, 32767, 32767, ra);      // unused operation
        issue(FN_NOP, 0, 0, ra);
        issue(FN_QUERY, 0, 32767, ra);        // user address at the last byte of the arena
        // neighbors busy, then a request the size of the freed hole
        issue(FN_ALLOC, 20, 0, ra);
        issue(FN_ALLOC, 20, 0, rb);
        issue(FN_ALLOC, 20, 0, rc);
        live_blocks.delete(live_blocks.size() - 2);
        issue(FN_FREE, 0, rb.granted_addr, rd);
        issue(FN_QUERY, 0, rc.granted_addr, rd);
        issue(FN_ALLOC, 20, 0, rd);           // first fit takes it from the big block ahead of the hole
        issue(FN_ALLOC, 30000, 0, rd);        // most of the remaining arena
        free_live(live_blocks.size() - 1);
        free_live(live_blocks.size() - 2);    // coalesces with the freed hole above
        free_live(0);
        issue(FN_QUERY, 0, ra.granted_addr, rd);
    endtask

    task automatic random_items(int count);
        t_rsp rsp;
        int sel;
        int unsigned sz;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 45 || (sel < 92 && live_blocks.size() == 0)) begin
                case ($urandom_range(0, 19))
                    0: sz = $urandom_range(1025, 32767);
                    1, 2, 3, 4, 5: sz = $urandom_range(65, 1024);
                    default: sz = $urandom_range(0, 64);
                endcase
                issue(FN_ALLOC, sz, $urandom_range(0, 32767), rsp);
            end else if (sel < 75) begin
                free_live($urandom_range(0, live_blocks.size() - 1));
            end else if (sel < 92) begin
                issue(FN_QUERY, $urandom_range(0, 32767),
                      live_blocks[$urandom_range(0, live_blocks.size() - 1)], rsp);
            end else begin
                // noise that leaves the heap intact
                case ($urandom_range(0, 2))
                    0: issue(FN_QUERY, $urandom_range(0, 32767), $urandom_range(0, 32767), rsp);
                    1: issue(FN_NOP, $urandom_range(0, 32767), $urandom_range(0, 32767), rsp);
                    default: issue(FN_FREE, $urandom_range(0, 32767),
                                   $urandom_range(0, TOP_HDR + BUSY_HDR - 1), rsp);
                endcase
            end
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus sequence
    // ---------------------------------------------------------------
    initial begin
        t_rsp rsp;
        heap_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // the unused policy first, then every real one
        drain_and_set_policy(POL_SPARE);
        directed_items();
        random_items(RANDOM_PER_PHASE);
        drain_and_set_policy(POL_BEST);
        random_items(RANDOM_PER_PHASE);
        drain_and_set_policy(POL_WORST);
        random_items(RANDOM_PER_PHASE);
        drain_and_set_policy(POL_FIRST);
        random_items(RANDOM_PER_PHASE);
        // a free at an address inside a block, last since it scrambles the heap
        issue(FN_FREE, 0, 13, rsp);
        issue(FN_QUERY, 0, 13, rsp);

        while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d grants, %0d refusals, %0d frees, %0d queries, %0d others",
                 n_granted, n_refused, n_frees, n_queries, n_other);
        $display("checked %0d responses under all four policy settings", n_checked);
        if (n_errors == 0) begin
            $display("[free_list_heap_allocator_top] OK");
        end else begin
            $display("[free_list_heap_allocator_top] ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // request driver: bursts of random length separated by random gaps
    // ---------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        logic holding;
        holding = in_valid;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                void'(pending_reqs.pop_front());
                holding = 1'b0;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                end
            end
            // a request that is up stays up, unchanged, until taken
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    in_valid <= 1'b1;
                    in_req   <= pending_reqs[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // response monitor with its own stall pattern
    // ---------------------------------------------------------------
    int stall_mode = 0;
    int stall_span = 0;

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on response %0d: %s got %0d expected %0d",
                 n_checked, field, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected response, status", out_rsp.status, 0);
            end else begin
                want = expected_rsps.pop_front();
                if (out_rsp.status !== want.status)
                    report_mismatch("status", out_rsp.status, want.status);
                if (out_rsp.granted_addr !== want.granted_addr)
                    report_mismatch("granted_addr", out_rsp.granted_addr, want.granted_addr);
                if (out_rsp.usable_size !== want.usable_size)
                    report_mismatch("usable_size", out_rsp.usable_size, want.usable_size);
            end
            n_checked++;
        end
        // modes: free flowing, light stalls, heavy stalls, long stall runs
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 300);
        end else begin
            stall_span--;
        end
        case (stall_mode)
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ($urandom_range(0, 9) < 8);
            3: out_stall <= (stall_span % 40) < 25;
            default: out_stall <= 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // watchdog: cycles with no handshake on either channel
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles", quiet_cycles);
            $display("[free_list_heap_allocator_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
